>>> rtl/lzss_pkg.sv
package lzss_pkg;

  // field widths fixed by the stream format
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 17;
  localparam int CAUSE_W = 2;
  localparam int POS_W   = 12;
  localparam int LEN_W   = 5;

  // output limit after reset
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 17'd65536;

  // end causes
  localparam logic [CAUSE_W-1:0] CAUSE_MARKER = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_LIMIT  = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_INPUT  = 2'd2;

  // reference length offset
  localparam logic [LEN_W-1:0] LEN_BIAS = 5'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY
  } state_t;

  // what the next compressed byte is
  typedef enum logic [1:0] {
    PH_TAG,
    PH_ITEM,
    PH_PAIR
  } phase_t;

endpackage

>>> rtl/lzss_if.sv
// compressed byte channel
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_first;
  logic       stream_last;

  modport source (output valid, in_byte, stream_first, stream_last, input ready);
  modport sink (input valid, in_byte, stream_first, stream_last, output ready);
endinterface

// decompressed result channel
interface lzss_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        run_last;
  logic        stream_done;
  logic [1:0]  end_cause;
  logic [16:0] bytes_out;

  modport source (output valid, data_byte, byte_valid, run_last, stream_done, end_cause,
                  bytes_out, input ready);
  modport sink (input valid, data_byte, byte_valid, run_last, stream_done, end_cause,
                bytes_out, output ready);
endinterface

>>> rtl/lzss_win_ram.sv
module lzss_win_ram #(
  parameter int DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [lzss_pkg::BYTE_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [lzss_pkg::BYTE_W-1:0]    rd_data
);
  import lzss_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, a same-cycle write to the same entry is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> rtl/lzss_window_decoder_top.sv
// LZSS decoder with a WINDOW_DEPTH-byte history window held in one single-port-write,
// one-read-port synchronous memory. Compressed bytes enter on in_item, one result per
// decompressed byte leaves on out_item, plus one byte-less result when a stream ends on a
// byte that emits nothing. The second half of a reference of L bytes is copied out of the
// window with one window read and one window write per output byte. After reset the window
// is swept to zero, one entry a cycle, across all WINDOW_DEPTH entries (4096 by default); no
// input is taken during that sweep, while the output limit register can be written at any
// time through cfg_wr_en.
module lzss_window_decoder_top #(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lzss_pkg::COUNT_W-1:0]  cfg_wr_data,
  lzss_in_if.sink                       in_item,
  lzss_out_if.source                    out_item
);
  import lzss_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  // control and stream state
  state_t             state, state_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic [AW-1:0]      wp, wp_next;
  logic [2:0]         fidx, fidx_next;
  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  flag_byte, flag_next;
  logic [BYTE_W-1:0]  pair_low, pair_low_next;
  logic [COUNT_W-1:0] prod, prod_next;
  logic               halted, halted_next;
  logic [COUNT_W-1:0] limit;

  // copy engine
  logic [AW-1:0]      rd_ptr, rd_ptr_next;
  logic [LEN_W-1:0]   issue_left, issue_left_next;
  logic [LEN_W-1:0]   emit_left, emit_left_next;
  logic               copy_last, copy_last_next;
  logic               pend, pend_next;

  // output register
  logic               out_valid, out_valid_next;
  logic [BYTE_W-1:0]  o_data, o_data_next;
  logic               o_bvalid, o_bvalid_next;
  logic               o_run_last, o_run_last_next;
  logic               o_done, o_done_next;
  logic [CAUSE_W-1:0] o_cause, o_cause_next;
  logic [COUNT_W-1:0] o_count, o_count_next;

  // window memory ports
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [BYTE_W-1:0]  wr_data, rd_data;

  logic               in_ready;
  logic               out_free;

  lzss_win_ram #(
    .DEPTH (WINDOW_DEPTH)
  ) u_win (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free       = !out_valid || out_item.ready;
  assign in_item.ready  = in_ready;

  assign out_item.valid       = out_valid;
  assign out_item.data_byte   = o_data;
  assign out_item.byte_valid  = o_bvalid;
  assign out_item.run_last    = o_run_last;
  assign out_item.stream_done = o_done;
  assign out_item.end_cause   = o_cause;
  assign out_item.bytes_out   = o_count;

  // next state, memory access and result generation
  always_comb begin
    logic [AW-1:0]      wp_e;
    logic [2:0]         fidx_e;
    phase_t             ph_e;
    logic [COUNT_W-1:0] prod_e;
    logic               halt_e;
    logic [COUNT_W-1:0] prod_inc;
    logic               hit;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic               consume;
    logic               fin;

    state_next      = state;
    clr_addr_next   = clr_addr;
    wp_next         = wp;
    fidx_next       = fidx;
    phase_next      = phase;
    flag_next       = flag_byte;
    pair_low_next   = pair_low;
    prod_next       = prod;
    halted_next     = halted;
    rd_ptr_next     = rd_ptr;
    issue_left_next = issue_left;
    emit_left_next  = emit_left;
    copy_last_next  = copy_last;
    pend_next       = pend;
    out_valid_next  = out_valid && !out_item.ready;
    o_data_next     = o_data;
    o_bvalid_next   = o_bvalid;
    o_run_last_next = o_run_last;
    o_done_next     = o_done;
    o_cause_next    = o_cause;
    o_count_next    = o_count;
    wr_en           = 1'b0;
    wr_addr         = wp;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = rd_ptr;
    in_ready        = 1'b0;

    wp_e     = wp;
    fidx_e   = fidx;
    ph_e     = phase;
    prod_e   = prod;
    halt_e   = halted;
    prod_inc = '0;
    hit      = 1'b0;
    pos      = {in_item.in_byte, pair_low[7:4]};
    len      = LEN_W'({1'b0, pair_low[3:0]}) + LEN_BIAS;
    consume  = 1'b0;
    fin      = 1'b0;

    case (state)
      // sweep the window to zero after reset
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(WINDOW_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      // decode one compressed byte
      ST_IDLE: begin
        in_ready = out_free;
        if (in_item.valid && out_free) begin
          if (in_item.stream_first) begin
            wp_e          = AW'(1);
            fidx_e        = 3'd0;
            ph_e          = PH_TAG;
            prod_e        = '0;
            halt_e        = 1'b0;
            pair_low_next = '0;
          end
          wp_next     = wp_e;
          fidx_next   = fidx_e;
          phase_next  = ph_e;
          prod_next   = prod_e;
          halted_next = halt_e;
          prod_inc    = prod_e + COUNT_W'(1);
          hit         = (prod_inc >= limit);

          // default byte-less result, made valid only where a result is due
          o_data_next     = '0;
          o_bvalid_next   = 1'b0;
          o_run_last_next = 1'b1;
          o_done_next     = 1'b1;
          o_cause_next    = CAUSE_INPUT;
          o_count_next    = prod_e;

          if (!halt_e) begin
            if (prod_e >= limit) begin
              out_valid_next = 1'b1;
              o_cause_next   = CAUSE_LIMIT;
              halted_next    = 1'b1;
            end else begin
              case (ph_e)
                PH_ITEM: begin
                  if (flag_byte[fidx_e]) begin
                    // low half of a reference
                    pair_low_next = in_item.in_byte;
                    phase_next    = PH_PAIR;
                    if (in_item.stream_last) begin
                      out_valid_next = 1'b1;
                      halted_next    = 1'b1;
                    end
                  end else begin
                    // literal
                    wr_en          = 1'b1;
                    wr_addr        = wp_e;
                    wr_data        = in_item.in_byte;
                    wp_next        = wp_e + AW'(1);
                    prod_next      = prod_inc;
                    out_valid_next = 1'b1;
                    o_data_next    = in_item.in_byte;
                    o_bvalid_next  = 1'b1;
                    o_count_next   = prod_inc;
                    o_done_next    = hit || in_item.stream_last;
                    o_cause_next   = hit ? CAUSE_LIMIT :
                                     in_item.stream_last ? CAUSE_INPUT : CAUSE_MARKER;
                    halted_next    = hit || in_item.stream_last;
                    if (fidx_e == 3'd7) begin
                      fidx_next  = 3'd0;
                      phase_next = PH_TAG;
                    end else begin
                      fidx_next  = fidx_e + 3'd1;
                      phase_next = PH_ITEM;
                    end
                  end
                end

                PH_PAIR: begin
                  if (pos == '0) begin
                    // end marker
                    out_valid_next = 1'b1;
                    o_cause_next   = CAUSE_MARKER;
                    halted_next    = 1'b1;
                  end else begin
                    // start a copy, first read issued now
                    rd_en           = 1'b1;
                    rd_addr         = AW'(pos);
                    rd_ptr_next     = AW'(pos) + AW'(1);
                    issue_left_next = len - LEN_W'(1);
                    emit_left_next  = len;
                    copy_last_next  = in_item.stream_last;
                    pend_next       = 1'b1;
                    state_next      = ST_COPY;
                    if (fidx_e == 3'd7) begin
                      fidx_next  = 3'd0;
                      phase_next = PH_TAG;
                    end else begin
                      fidx_next  = fidx_e + 3'd1;
                      phase_next = PH_ITEM;
                    end
                  end
                end

                default: begin
                  // tag byte
                  flag_next  = in_item.in_byte;
                  fidx_next  = 3'd0;
                  phase_next = PH_ITEM;
                  if (in_item.stream_last) begin
                    out_valid_next = 1'b1;
                    halted_next    = 1'b1;
                  end
                end
              endcase
            end
          end
        end
      end

      // copy out of the window, one byte per cycle while the result side is not stalled
      ST_COPY: begin
        consume  = pend && out_free;
        prod_inc = prod + COUNT_W'(1);
        hit      = (prod_inc >= limit);
        fin      = (emit_left == LEN_W'(1)) || hit;
        if (consume) begin
          wr_en           = 1'b1;
          wr_addr         = wp;
          wr_data         = rd_data;
          wp_next         = wp + AW'(1);
          prod_next       = prod_inc;
          emit_left_next  = emit_left - LEN_W'(1);
          pend_next       = 1'b0;
          out_valid_next  = 1'b1;
          o_data_next     = rd_data;
          o_bvalid_next   = 1'b1;
          o_count_next    = prod_inc;
          o_run_last_next = fin;
          o_done_next     = fin && (hit || copy_last);
          o_cause_next    = (fin && hit) ? CAUSE_LIMIT : (fin && copy_last) ? CAUSE_INPUT
                                                                             : CAUSE_MARKER;
          if (fin) begin
            halted_next = hit || copy_last;
            state_next  = ST_IDLE;
          end
        end
        if ((issue_left != '0) && (!pend || consume) && !(consume && fin)) begin
          rd_en           = 1'b1;
          rd_addr         = rd_ptr;
          rd_ptr_next     = rd_ptr + AW'(1);
          issue_left_next = issue_left - LEN_W'(1);
          pend_next       = 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      wp         <= AW'(1);
      fidx       <= 3'd0;
      phase      <= PH_TAG;
      flag_byte  <= '0;
      pair_low   <= '0;
      prod       <= '0;
      halted     <= 1'b0;
      issue_left <= '0;
      emit_left  <= '0;
      copy_last  <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      clr_addr   <= clr_addr_next;
      wp         <= wp_next;
      fidx       <= fidx_next;
      phase      <= phase_next;
      flag_byte  <= flag_next;
      pair_low   <= pair_low_next;
      prod       <= prod_next;
      halted     <= halted_next;
      issue_left <= issue_left_next;
      emit_left  <= emit_left_next;
      copy_last  <= copy_last_next;
      pend       <= pend_next;
      out_valid  <= out_valid_next;
    end
  end

  // output limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    o_data     <= o_data_next;
    o_bvalid   <= o_bvalid_next;
    o_run_last <= o_run_last_next;
    o_done     <= o_done_next;
    o_cause    <= o_cause_next;
    o_count    <= o_count_next;
  end

endmodule

>>> test/lzss_decode_checker.sv
module lzss_decode_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lzss_pkg::COUNT_W-1:0] cfg_wr_data,
  lzss_in_if                           in_mon,
  lzss_out_if                          out_mon,
  output int                           error_count,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  localparam int WIN_DEPTH = 1 << POS_W;

  // one decoded result as seen on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               byte_valid;
    logic               run_last;
    logic               stream_done;
    logic [CAUSE_W-1:0] cause;
    logic [COUNT_W-1:0] count;
  } decoded_t;

  // decoder state mirror
  logic [BYTE_W-1:0]  window_mem [0:WIN_DEPTH-1];
  logic [POS_W-1:0]   wr_ptr;
  logic [BYTE_W-1:0]  tag_flags;
  logic [2:0]         flag_pos;
  phase_t             cur_phase;
  logic [BYTE_W-1:0]  low_half;
  logic [COUNT_W-1:0] produced;
  bit                 halted;
  logic [COUNT_W-1:0] limit;

  decoded_t decoded_q[$];
  decoded_t run_q[$];
  int       fails = 0;

  task automatic start_stream();
    wr_ptr    = POS_W'(1);
    flag_pos  = 3'd0;
    cur_phase = PH_TAG;
    low_half  = '0;
    produced  = '0;
    halted    = 1'b0;
  endtask

  // output one byte and store it in the history window
  task automatic emit(input logic [BYTE_W-1:0] b);
    decoded_t r;
    window_mem[wr_ptr] = b;
    wr_ptr   = wr_ptr + 1'b1;
    produced = produced + 1'b1;
    r = '0;
    r.data       = b;
    r.byte_valid = 1'b1;
    r.count      = produced;
    run_q.push_back(r);
  endtask

  task automatic advance_flag();
    if (flag_pos == 3'd7) begin
      flag_pos  = 3'd0;
      cur_phase = PH_TAG;
    end else begin
      flag_pos  = flag_pos + 1'b1;
      cur_phase = PH_ITEM;
    end
  endtask

  // decode one compressed byte into the results it causes
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic first, input logic last);
    logic [15:0]      pair;
    logic [POS_W-1:0] pos;
    int               len;
    int               cause;
    decoded_t         r;
    run_q.delete();
    if (first) start_stream();
    if (halted) return;
    cause = -1;
    if (produced >= limit) begin
      cause = int'(CAUSE_LIMIT);
    end else begin
      case (cur_phase)
        PH_TAG: begin
          tag_flags = b;
          flag_pos  = 3'd0;
          cur_phase = PH_ITEM;
        end
        PH_ITEM: begin
          if (tag_flags[flag_pos]) begin
            low_half  = b;
            cur_phase = PH_PAIR;
          end else begin
            emit(b);
            advance_flag();
          end
        end
        default: begin
          pair = {b, low_half};
          pos  = pair[15:4];
          len  = int'(pair[3:0]) + int'(LEN_BIAS);
          if (pos == '0) begin
            cause = int'(CAUSE_MARKER);
          end else begin
            for (int i = 0; i < len && produced < limit; i++) begin
              emit(window_mem[pos]);
              pos = pos + 1'b1;
            end
            advance_flag();
          end
        end
      endcase
    end
    // limit beats input exhaustion
    if (cause < 0) begin
      if (produced >= limit) cause = int'(CAUSE_LIMIT);
      else if (last) cause = int'(CAUSE_INPUT);
    end
    if (cause >= 0) begin
      halted = 1'b1;
      if (run_q.size() == 0) begin
        r = '0;
        r.count = produced;
        run_q.push_back(r);
      end
      r = run_q.pop_back();
      r.stream_done = 1'b1;
      r.cause       = CAUSE_W'(cause);
      run_q.push_back(r);
    end
    if (run_q.size() > 0) begin
      r = run_q.pop_back();
      r.run_last = 1'b1;
      run_q.push_back(r);
    end
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] expv, input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      fails++;
    end
  endtask

  // compare one output transaction with the oldest expected result
  task automatic compare_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      $error("data_byte: expected no result, got %0d", out_mon.data_byte);
      fails++;
    end else begin
      want = decoded_q.pop_front();
      check_field("data_byte", 32'(want.data), 32'(out_mon.data_byte));
      check_field("byte_valid", 32'(want.byte_valid), 32'(out_mon.byte_valid));
      check_field("run_last", 32'(want.run_last), 32'(out_mon.run_last));
      check_field("stream_done", 32'(want.stream_done), 32'(out_mon.stream_done));
      check_field("end_cause", 32'(want.cause), 32'(out_mon.end_cause));
      check_field("bytes_out", 32'(want.count), 32'(out_mon.bytes_out));
    end
  endtask

  // watch config, input and output transactions
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_DEPTH; i++) window_mem[i] = '0;
      tag_flags = '0;
      limit     = LIMIT_RESET;
      start_stream();
      decoded_q.delete();
    end else begin
      if (cfg_wr_en) limit = cfg_wr_data;
      if (in_mon.valid && in_mon.ready)
        decode_byte(in_mon.in_byte, in_mon.stream_first, in_mon.stream_last);
      if (out_mon.valid && out_mon.ready) compare_result();
    end
    outstanding <= decoded_q.size();
    error_count <= fails;
  end

endmodule

>>> test/tb_lzss_window_decoder_top.sv
module tb_lzss_window_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lzss_pkg::*;

  localparam int RAND_ITEMS     = 110;
  localparam int CALM_ITEMS     = 25;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
  } in_tx_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  int                 error_count;
  int                 outstanding;
  bit                 in_idle_en = 1'b1;
  bit                 out_stall_en = 1'b1;
  int                 ready_hold = 0;
  int                 quiet_cycles = 0;
  in_tx_t             stream_q[$];
  bit                 first_mark;

  lzss_in_if  in_ch ();
  lzss_out_if out_ch ();

  lzss_window_decoder_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_ch),
    .out_item    (out_ch)
  );

  lzss_decode_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side stalls in bursts of random length
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_stall_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 16);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // stop if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_lzss_window_decoder_top: done, errors");
      $finish;
    end
  end

  // stream building
  function automatic void push_byte(logic [7:0] b);
    in_tx_t t;
    t.b     = b;
    t.first = first_mark;
    t.last  = 1'b0;
    first_mark = 1'b0;
    stream_q.push_back(t);
  endfunction

  function automatic void mark_last();
    in_tx_t t;
    t = stream_q.pop_back();
    t.last = 1'b1;
    stream_q.push_back(t);
  endfunction

  function automatic void push_pair(logic [11:0] pos, logic [3:0] len);
    push_byte({pos[3:0], len});
    push_byte(pos[11:4]);
  endfunction

  // mostly recent positions, sometimes anywhere in the window
  function automatic logic [11:0] pick_pos();
    if ($urandom_range(0, 3) == 0) return 12'($urandom_range(1, 4095));
    return 12'($urandom_range(1, 300));
  endfunction

  // one tag byte and its eight items
  function automatic void push_group();
    logic [7:0] tag;
    tag = 8'($urandom_range(0, 255));
    push_byte(tag);
    for (int i = 0; i < 8; i++) begin
      if (tag[i]) push_pair(pick_pos(), 4'($urandom_range(0, 15)));
      else push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // tag whose first item is a position-zero reference
  function automatic void push_marker();
    push_byte(8'($urandom_range(0, 255)) | 8'h01);
    push_pair(12'h000, 4'($urandom_range(0, 15)));
  endfunction

  function automatic logic [COUNT_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COUNT_W'(1);
      2:       return COUNT_W'($urandom_range(2, 40));
      3:       return COUNT_W'(65535);
      4:       return COUNT_W'($urandom_range(41, 600));
      default: return LIMIT_RESET;
    endcase
  endfunction

  // drive one input transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic [7:0] b, input logic first, input logic last);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.stream_first <= first;
    in_ch.stream_last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic flush_stream();
    foreach (stream_q[i]) send_item(stream_q[i].b, stream_q[i].first, stream_q[i].last);
    stream_q.delete();
  endtask

  // hold off until every expected result is out and the block has settled
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int rand_items;
    int kind;
    int cut;
    bit paused;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.stream_first = 1'b0;
    in_ch.stream_last  = 1'b0;
    out_ch.ready       = 1'b0;
    rand_items = 0;
    paused     = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_limit(LIMIT_RESET);

    // literals at the extremes, an overlapping 17-byte copy, a copy from an
    // unwritten entry that wraps, then the end marker and an ignored byte
    first_mark = 1'b1;
    push_byte(8'h02);
    push_byte(8'hFF);
    push_pair(12'd1, 4'hF);
    push_byte(8'h00);
    push_byte(8'h5A);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(8'hC3);
    push_byte(8'hFF);
    push_pair(12'hFFF, 4'h0);
    push_pair(12'h000, 4'h3);
    push_byte(8'h12);
    flush_stream();

    // copy cut off by the output limit
    wait_idle();
    write_limit(COUNT_W'(3));
    first_mark = 1'b1;
    push_byte(8'h01);
    push_pair(12'd2, 4'hF);
    flush_stream();

    // limit reached on the last byte
    first_mark = 1'b1;
    push_byte(8'h00);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    mark_last();
    flush_stream();

    // zero limit stops the first byte
    wait_idle();
    write_limit('0);
    first_mark = 1'b1;
    push_byte(8'h44);
    flush_stream();

    // reference cut short by the end of input
    wait_idle();
    write_limit(LIMIT_RESET);
    first_mark = 1'b1;
    push_byte(8'h01);
    push_byte(8'h11);
    mark_last();
    flush_stream();

    // random streams
    while (rand_items < RAND_ITEMS) begin
      in_idle_en    = (rand_items < RAND_ITEMS - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
      out_stall_en <= (rand_items < RAND_ITEMS - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        write_limit(pick_limit());
      end
      if (!paused && rand_items >= RAND_ITEMS / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // well-formed stream, ended by marker, by last byte, or left open
        first_mark = 1'b1;
        repeat ($urandom_range(1, 3)) push_group();
        case ($urandom_range(0, 2))
          0:       push_marker();
          1:       mark_last();
          default: ;
        endcase
      end else if (kind == 6) begin
        // stream broken off at a random byte
        first_mark = 1'b1;
        push_group();
        cut = $urandom_range(1, stream_q.size() - 1);
        repeat (cut) void'(stream_q.pop_back());
        mark_last();
      end else if (kind == 7) begin
        // maybe carry on the open stream
        first_mark = bit'($urandom_range(0, 1));
        push_group();
        if ($urandom_range(0, 1) == 0) mark_last();
      end else begin
        // noise with random stream flags
        repeat ($urandom_range(3, 8)) begin
          first_mark = ($urandom_range(0, 5) == 0);
          push_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 4) == 0) mark_last();
        end
      end
      rand_items += stream_q.size();
      flush_stream();
    end

    in_idle_en    = 1'b0;
    out_stall_en <= 1'b0;
    wait_idle();
    if (error_count == 0 && outstanding == 0) begin
      $display("tb_lzss_window_decoder_top: done, clean");
    end else begin
      $display("tb_lzss_window_decoder_top: done, errors");
    end
    $finish;
  end

endmodule

>>> lzss_window_decoder_top.f
rtl/lzss_pkg.sv
rtl/lzss_if.sv
rtl/lzss_win_ram.sv
rtl/lzss_window_decoder_top.sv
test/lzss_decode_checker.sv
test/tb_lzss_window_decoder_top.sv
